>>> rtl/core/imu_frame_parser_decoder_defines.svh
// ----------------------------------------------------------------------------
// imu_frame_parser_decoder_defines.svh
// Assertion macros shared by the frame parser checker.
// ----------------------------------------------------------------------------
`ifndef IMU_FRAME_PARSER_DECODER_DEFINES_SVH
`define IMU_FRAME_PARSER_DECODER_DEFINES_SVH

// Clocked assertion, off while reset is held.
`define IMUFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define IMUFP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/imufp_pkg.sv
// ----------------------------------------------------------------------------
// imufp_pkg
// Widths, frame IDs and result codes of the IMU frame parser.
// ----------------------------------------------------------------------------
package imufp_pkg;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned AXIS_W       = 23;
  localparam int unsigned CNT_W        = 16;
  localparam int unsigned KEPT_PAYLOAD = 6;
  localparam int unsigned PIDX_W       = $clog2(KEPT_PAYLOAD);

  // out_tdata: axis_x, axis_y, axis_z, sync count, checksum count, pad to bytes
  localparam int unsigned OUT_BITS = 3 * AXIS_W + 2 * CNT_W;
  localparam int unsigned DATA_W   = ((OUT_BITS + 7) / 8) * 8;
  localparam int unsigned USER_W   = 4;

  localparam logic [7:0] ID_ACCEL = 8'h15;
  localparam logic [7:0] ID_GYRO  = 8'h25;
  localparam logic [7:0] ID_EULER = 8'h45;
  localparam logic [7:0] SYNC_RST = 8'h5A;

  localparam logic signed [AXIS_W-1:0] GYRO_SCALE = 23'sd125;

  typedef enum logic [1:0] {
    ST_DECODED  = 2'd0,
    ST_UNKNOWN  = 2'd1,
    ST_CSUM_ERR = 2'd2,
    ST_SYNC_ERR = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    KIND_ACCEL = 2'd0,
    KIND_GYRO  = 2'd1,
    KIND_EULER = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

endpackage

>>> rtl/core/imu_frame_parser_decoder.sv
// ----------------------------------------------------------------------------
// imu_frame_parser_decoder
// Byte-serial sync/ID/length/checksum frame parser with axis decode.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one received link byte per word, rx_byte in in_tdata[7:0].
//   out_* : at most one result word per input byte. out_tuser carries
//           status and sensor kind, out_tdata the three axis values and
//           both error counters (counter values after that byte).
//   cfg_* : cfg_wr_en writes cfg_wr_data into the sync byte register
//           (reset 0x5A). Write only while the block is idle.
// Path: a byte is registered in the input register on accept and parsed by
//   the combinational parse stage; its result, if any, loads the output
//   register when the parse stage advances, and is offered from there.
// Throughput: one byte per cycle unless the output stalls; the parse stage is
//   a single pass of compare/add logic with three 16-bit by 125 gyro multiplies.
// Reset (rst_n low, synchronous): parser back to sync hunt, sum, length,
//   ID, payload store and counters cleared, no word held on either side.
// Stall: when out_tready is low with a result waiting, the parse stage
//   holds; the input register takes one more byte only if it is empty,
//   and in_tready stays low while it holds one until the result word moves.
// ----------------------------------------------------------------------------
module imu_frame_parser_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  // input byte stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] rx_byte
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [imufp_pkg::DATA_W-1:0]  out_tdata,  // [22:0] axis_x, [45:23] axis_y,
                                                    // [68:46] axis_z,
                                                    // [84:69] sync_error_count,
                                                    // [100:85] checksum_error_count,
                                                    // [103:101] zero
  output logic [imufp_pkg::USER_W-1:0]  out_tuser,  // [1:0] status, [3:2] sensor_kind
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [7:0]                    cfg_wr_data // [7:0] sync_byte
);

  localparam int unsigned AW = imufp_pkg::AXIS_W;
  localparam int unsigned CW = imufp_pkg::CNT_W;
  localparam int unsigned KP = imufp_pkg::KEPT_PAYLOAD;

  typedef enum logic [2:0] {
    PS_HUNT  = 3'd0,
    PS_SYNC2 = 3'd1,
    PS_ID    = 3'd2,
    PS_LEN   = 3'd3,
    PS_BODY  = 3'd4
  } pstate_t;

  // config
  logic [7:0] sync_byte_r;

  // input register
  logic       in_v_r, in_v_nxt;
  logic [7:0] in_byte_r;
  logic       in_acc;

  // parser state
  pstate_t           ps_r, ps_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic [7:0]        len_r, len_nxt;
  logic [7:0]        idx_r, idx_nxt;
  logic [7:0]        id_r, id_nxt;
  logic [7:0]        pay_r   [KP];
  logic [7:0]        pay_nxt [KP];
  logic [CW-1:0]     sync_cnt_r, sync_cnt_nxt;
  logic [CW-1:0]     csum_cnt_r, csum_cnt_nxt;

  // result
  logic                  res_v;
  imufp_pkg::status_t    res_status;
  imufp_pkg::kind_t      res_kind;
  logic signed [AW-1:0]  res_x, res_y, res_z;
  logic signed [AW-1:0]  raw_x, raw_y, raw_z;

  // output register
  logic                          out_v_r, out_v_nxt;
  logic [imufp_pkg::DATA_W-1:0]  out_data_r;
  logic [imufp_pkg::USER_W-1:0]  out_user_r;

  logic advance;
  logic in_store;   // index still inside the kept part of the payload

  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;
  assign in_acc    = in_tvalid && in_tready;

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign in_store = (idx_r < 8'(KP));

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_acc) begin
      in_v_nxt = 1'b1;
    end else if (advance) begin
      in_v_nxt = 1'b0;
    end
  end

  // parse one byte
  always_comb begin
    ps_nxt       = ps_r;
    sum_nxt      = sum_r;
    len_nxt      = len_r;
    idx_nxt      = idx_r;
    id_nxt       = id_r;
    sync_cnt_nxt = sync_cnt_r;
    csum_cnt_nxt = csum_cnt_r;
    for (int i = 0; i < KP; i++) begin
      pay_nxt[i] = pay_r[i];
    end
    raw_x      = '0;
    raw_y      = '0;
    raw_z      = '0;
    res_v      = 1'b0;
    res_status = imufp_pkg::ST_SYNC_ERR;
    res_kind   = imufp_pkg::KIND_NONE;
    res_x      = '0;
    res_y      = '0;
    res_z      = '0;

    unique case (ps_r)
      PS_HUNT: begin
        if (in_byte_r == sync_byte_r) begin
          sum_nxt = in_byte_r;
          ps_nxt  = PS_SYNC2;
        end
      end
      PS_SYNC2: begin
        if (in_byte_r == sync_byte_r) begin
          sum_nxt = sum_r + in_byte_r;
          ps_nxt  = PS_ID;
        end else begin
          // bad second sync, byte is not retried as a first sync
          sync_cnt_nxt = sync_cnt_r + 1'b1;
          ps_nxt       = PS_HUNT;
          res_v        = 1'b1;
        end
      end
      PS_ID: begin
        id_nxt  = in_byte_r;
        sum_nxt = sum_r + in_byte_r;
        ps_nxt  = PS_LEN;
      end
      PS_LEN: begin
        len_nxt = in_byte_r;
        sum_nxt = sum_r + in_byte_r;
        idx_nxt = '0;
        ps_nxt  = PS_BODY;
      end
      PS_BODY: begin
        // short frames also drop the checksum byte into the store
        if (in_store) begin
          pay_nxt[idx_r[imufp_pkg::PIDX_W-1:0]] = in_byte_r;
        end
        // big-endian axis words from the store as it stands after this byte
        raw_x = AW'(signed'({pay_nxt[0], pay_nxt[1]}));
        raw_y = AW'(signed'({pay_nxt[2], pay_nxt[3]}));
        raw_z = AW'(signed'({pay_nxt[4], pay_nxt[5]}));
        if (idx_r < len_r) begin
          sum_nxt = sum_r + in_byte_r;
          idx_nxt = idx_r + 1'b1;
        end else begin
          ps_nxt = PS_HUNT;
          res_v  = 1'b1;
          if (sum_r != in_byte_r) begin
            csum_cnt_nxt = csum_cnt_r + 1'b1;
            res_status   = imufp_pkg::ST_CSUM_ERR;
          end else if (id_r == imufp_pkg::ID_ACCEL) begin
            res_status = imufp_pkg::ST_DECODED;
            res_kind   = imufp_pkg::KIND_ACCEL;
            res_x      = raw_x;
            res_y      = raw_y;
            res_z      = raw_z;
          end else if (id_r == imufp_pkg::ID_GYRO) begin
            res_status = imufp_pkg::ST_DECODED;
            res_kind   = imufp_pkg::KIND_GYRO;
            res_x      = raw_x * imufp_pkg::GYRO_SCALE;
            res_y      = raw_y * imufp_pkg::GYRO_SCALE;
            res_z      = raw_z * imufp_pkg::GYRO_SCALE;
          end else if (id_r == imufp_pkg::ID_EULER) begin
            res_status = imufp_pkg::ST_DECODED;
            res_kind   = imufp_pkg::KIND_EULER;
            res_x      = raw_x;
            res_y      = raw_y;
            res_z      = raw_z;
          end else begin
            res_status = imufp_pkg::ST_UNKNOWN;
          end
        end
      end
      default: begin
        ps_nxt = PS_HUNT;
      end
    endcase
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (advance && res_v) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_byte_r <= imufp_pkg::SYNC_RST;
      in_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      ps_r        <= PS_HUNT;
      sum_r       <= '0;
      len_r       <= '0;
      idx_r       <= '0;
      id_r        <= '0;
      sync_cnt_r  <= '0;
      csum_cnt_r  <= '0;
      for (int i = 0; i < KP; i++) begin
        pay_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        sync_byte_r <= cfg_wr_data;
      end
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
      if (advance) begin
        ps_r       <= ps_nxt;
        sum_r      <= sum_nxt;
        len_r      <= len_nxt;
        idx_r      <= idx_nxt;
        id_r       <= id_nxt;
        sync_cnt_r <= sync_cnt_nxt;
        csum_cnt_r <= csum_cnt_nxt;
        for (int i = 0; i < KP; i++) begin
          pay_r[i] <= pay_nxt[i];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_byte_r <= in_tdata;
    end
    if (advance && res_v) begin
      out_user_r <= {res_kind, res_status};
      out_data_r <= imufp_pkg::DATA_W'({csum_cnt_nxt, sync_cnt_nxt, res_z, res_y, res_x});
    end
  end

endmodule

>>> rtl/core/imufp_checker.sv
// ----------------------------------------------------------------------------
// imufp_checker
// Port-level checks on the IMU frame parser, bound into the parser module.
// ----------------------------------------------------------------------------
`include "imu_frame_parser_decoder_defines.svh"

module imufp_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [7:0]                    in_tdata,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [imufp_pkg::DATA_W-1:0]  out_tdata,
  input  logic [imufp_pkg::USER_W-1:0]  out_tuser,
  input  logic                          cfg_wr_en,
  input  logic [7:0]                    cfg_wr_data
);

  localparam int unsigned CW   = imufp_pkg::CNT_W;
  localparam int unsigned AX3  = 3 * imufp_pkg::AXIS_W;

  logic          out_acc;
  logic [1:0]    st;
  logic [1:0]    kind;
  logic [CW-1:0] sync_cnt, csum_cnt;
  logic [CW-1:0] last_sync_r, last_csum_r;
  logic          in_seen;

  assign out_acc  = out_tvalid && out_tready;
  assign st       = out_tuser[1:0];
  assign kind     = out_tuser[3:2];
  assign sync_cnt = out_tdata[AX3 +: CW];
  assign csum_cnt = out_tdata[AX3 + CW +: CW];
  assign in_seen  = in_tvalid && in_tready && (in_tdata == in_tdata) &&
                    (!cfg_wr_en || (cfg_wr_data == cfg_wr_data));

  // counter values of the last delivered word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sync_r <= '0;
      last_csum_r <= '0;
    end else if (out_acc) begin
      last_sync_r <= sync_cnt;
      last_csum_r <= csum_cnt;
    end
  end

  `IMUFP_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_tvalid, "out word present after reset")

  `IMUFP_ASSERT(a_hold, (out_tvalid && !out_tready) |=> out_tvalid, "out word dropped while stalled")

  `IMUFP_ASSERT(a_not_decoded, (out_tvalid && st != imufp_pkg::ST_DECODED) |-> (kind == imufp_pkg::KIND_NONE && out_tdata[AX3-1:0] == '0), "non-decoded word carries axis data")

  `IMUFP_ASSERT(a_sync_cnt, out_acc |-> (sync_cnt == ((st == imufp_pkg::ST_SYNC_ERR) ? CW'(last_sync_r + 1'b1) : last_sync_r)), "sync error count out of step")

  `IMUFP_ASSERT(a_csum_cnt, (out_acc || in_seen) |-> (!out_acc || csum_cnt == ((st == imufp_pkg::ST_CSUM_ERR) ? CW'(last_csum_r + 1'b1) : last_csum_r)), "checksum error count out of step")

endmodule

bind imu_frame_parser_decoder imufp_checker u_imufp_checker (.*);
